// ===== rtl/srv_pkg.sv =====
`timescale 1ns / 1ps
// Package for the S-record line validator: sizes, status codes, hex decode.
// No dependencies.
package srv_pkg;

	localparam int LINE_BUFFER = 1024;
	localparam int CNT_W = $clog2(LINE_BUFFER);
	localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LINE_BUFFER - 1);

	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LF = 8'h66;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UF = 8'h46;
	localparam logic [7:0] SUM_GOOD = 8'hFF;
	localparam int MIN_LEN = 4;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK = 3'd0;
	localparam status_t ST_SHORT = 3'd1;
	localparam status_t ST_BAD_HDR = 3'd2;
	localparam status_t ST_BAD_LEN = 3'd3;
	localparam status_t ST_BAD_SUM = 3'd4;

	typedef struct packed {
		logic take;
		logic last;
		logic [7:0] ch;
	} char_xfer_t;

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'd0;
			if (c >= CH_0 && c <= CH_9) begin
				d = c - CH_0;
			end else if (c >= CH_LA && c <= CH_LF) begin
				d = c - CH_LA + 8'd10;
			end else if (c >= CH_UA && c <= CH_UF) begin
				d = c - CH_UA + 8'd10;
			end
			return d[3:0];
		end
	endfunction

endpackage

// ===== rtl/srv_char_if.sv =====
`timescale 1ns / 1ps
// Character channel: valid/ready handshake carrying one line character.
// Depends on nothing.
interface srv_char_if;
	logic valid;
	logic ready;
	logic [7:0] character;
	logic last_char;

	modport source(output valid, output character, output last_char, input ready);
	modport sink(input valid, input character, input last_char, output ready);
endinterface

// ===== rtl/srv_status_if.sv =====
`timescale 1ns / 1ps
// Status channel: valid/ready handshake carrying one line status.
// Depends on srv_pkg.
interface srv_status_if import srv_pkg::*;;
	logic valid;
	logic ready;
	status_t status;

	modport source(output valid, output status, input ready);
	modport sink(input valid, input status, output ready);
endinterface

// ===== rtl/srv_line_core.sv =====
`timescale 1ns / 1ps
// Per-line running state (count, header, count byte, checksum) and status decode.
// Depends on srv_pkg.
module srv_line_core import srv_pkg::*; (
	input logic clk,
	input logic arst_n,
	input char_xfer_t xfer,
	output status_t status
);

	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic hdr_q, hdr_n;
	logic [3:0] nib_q, nib_n;
	logic [7:0] rc_q, rc_n;
	logic [7:0] sum_q, sum_n;
	logic [7:0] byte_val;
	logic [CNT_W-1:0] k_idx;
	logic [CNT_W-1:0] len_lim;

	assign byte_val = {nib_q, hex_nibble(xfer.ch)};
	assign k_idx = CNT_W'(cnt_q - CNT_W'(3)) >> 1;

	always_comb begin
		cnt_n = cnt_q;
		hdr_n = hdr_q;
		nib_n = nib_q;
		rc_n = rc_q;
		sum_n = sum_q;
		if (xfer.take && cnt_q != CNT_MAX) begin
			cnt_n = cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(0)) begin
				if (xfer.ch != CH_S) hdr_n = 1'b0;
			end else if (cnt_q == CNT_W'(1)) begin
				if (xfer.ch < CH_0 || xfer.ch > CH_9) hdr_n = 1'b0;
			end else if (!cnt_q[0]) begin
				nib_n = hex_nibble(xfer.ch);
			end else if (k_idx == CNT_W'(0)) begin
				rc_n = byte_val;
				sum_n = byte_val;
			end else if (CMP_W'(k_idx) <= CMP_W'(rc_q)) begin
				sum_n = sum_q + byte_val;
			end
		end
	end

	assign len_lim = CNT_W'(cnt_n - CNT_W'(MIN_LEN)) >> 1;

	always_comb begin
		if (cnt_n < CNT_W'(MIN_LEN)) begin
			status = ST_SHORT;
		end else if (!hdr_n) begin
			status = ST_BAD_HDR;
		end else if (CMP_W'(rc_n) > CMP_W'(len_lim)) begin
			status = ST_BAD_LEN;
		end else if (sum_n != SUM_GOOD) begin
			status = ST_BAD_SUM;
		end else begin
			status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			hdr_q <= 1'b1;
			nib_q <= '0;
			rc_q <= '0;
			sum_q <= '0;
		end else if (xfer.take && xfer.last) begin
			cnt_q <= '0;
			hdr_q <= 1'b1;
			nib_q <= '0;
			rc_q <= '0;
			sum_q <= '0;
		end else if (xfer.take) begin
			cnt_q <= cnt_n;
			hdr_q <= hdr_n;
			nib_q <= nib_n;
			rc_q <= rc_n;
			sum_q <= sum_n;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX) else $error("char count past line buffer");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		xfer.take && xfer.last |=> cnt_q == '0 && hdr_q && sum_q == '0)
		else $error("line state not cleared after final character");

	a_ok_means_sum: assert property (@(posedge clk) disable iff (!arst_n)
		xfer.take && xfer.last && status == ST_OK |-> sum_n == SUM_GOOD && hdr_n)
		else $error("ok status without good header and checksum");

	a_hdr_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		xfer.take && !xfer.last && !hdr_q |=> !hdr_q)
		else $error("header flag recovered inside a line");

endmodule

// ===== rtl/srecord_line_validator.sv =====
`timescale 1ns / 1ps
// S-record line validator top level: input register, line state, status register.
// Depends on srv_pkg, srv_char_if, srv_status_if, srv_line_core.
//
// Takes one character per cycle, with last_char on the final one, and returns
// one status transaction per line, via the input and status registers, after
// the final character is accepted: ok, too short, bad header, wrong length or
// bad checksum. Every character moves through a single registered pass (input
// register, running state update, status register), so throughput is one
// character per clock. The input stalls only when a line end sits in the input
// register while the previous status has not yet been taken. Characters beyond
// LINE_BUFFER-1 in a line are ignored but still end the line on last_char.
module srecord_line_validator import srv_pkg::*; (
	input logic clk,
	input logic arst_n,
	srv_char_if.sink char_in,
	srv_status_if.source status_out
);

	logic valid_s1;
	logic last_s1;
	logic [7:0] char_s1;
	logic adv;
	logic out_valid_q;
	status_t status_q;
	status_t core_status;
	char_xfer_t xfer;

	assign adv = valid_s1 && (!last_s1 || !out_valid_q || status_out.ready);
	assign char_in.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_in.ready) begin
			valid_s1 <= char_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_in.ready && char_in.valid) begin
			char_s1 <= char_in.character;
			last_s1 <= char_in.last_char;
		end
	end

	assign xfer = '{take: adv, last: last_s1, ch: char_s1};

	srv_line_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.xfer(xfer),
		.status(core_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (status_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			status_q <= core_status;
		end
	end

	assign status_out.valid = out_valid_q;
	assign status_out.status = status_q;

endmodule
